>>> hdl/srt_pkg.sv
// Shared types and constants for the signed integer to radix text converter.
package srt_pkg;

    localparam int DATA_W       = 32;
    localparam int NUM_CELLS    = DATA_W;
    localparam int CNT_W        = $clog2(DATA_W);
    localparam int CHAR_W       = 8;
    localparam int ALPHA_CHARS  = 16;
    localparam int ALPHA_IDX_W  = $clog2(ALPHA_CHARS);
    localparam int RLEN_W       = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int MAX_BASE_DEF = 16;
    localparam int MIN_RADIX    = 2;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_LOW  = 2'd0,
        CFG_ALPHA_HIGH = 2'd1,
        CFG_RADIX_LEN  = 2'd2
    } cfg_reg_t;

    // Token passed from one digit cell to the next.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic carry;
        logic neg;
    } tok_t;

endpackage

>>> hdl/srt_feed.sv
// Input stage: takes a value and shifts its magnitude into the cell chain, MSB first.
module srt_feed (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [srt_pkg::DATA_W-1:0]  s_axis_tdata,
    output srt_pkg::tok_t               tok
);
    import srt_pkg::*;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DATA_W - 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] sh_reg, sh_next;
    logic              neg_reg, neg_next;
    logic              accept;
    logic              in_neg;

    assign s_axis_tready = adv && (!busy_reg || cnt_reg == LAST_CNT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_neg        = s_axis_tdata[DATA_W-1];

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = in_neg ? (DATA_W'(0) - s_axis_tdata) : s_axis_tdata;
            neg_next  = in_neg;
        end
        else if (adv && busy_reg)
        begin
            sh_next  = {sh_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_CNT)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
    end

    assign tok.valid = busy_reg;
    assign tok.first = (cnt_reg == '0);
    assign tok.last  = (cnt_reg == LAST_CNT);
    assign tok.carry = sh_reg[DATA_W-1];
    assign tok.neg   = neg_reg;

endmodule

>>> hdl/srt_cell.sv
// One digit cell: doubles its digit, adds the incoming carry and reduces by the radix.
module srt_cell #(
    parameter int DW = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic [DW:0]     radix,
    input  srt_pkg::tok_t   tok_in,
    output srt_pkg::tok_t   tok_out,
    output logic [DW-1:0]   cap
);
    import srt_pkg::*;

    logic [DW-1:0] d_reg, d_next;
    logic [DW-1:0] cap_reg, cap_next;
    tok_t          tok_reg, tok_next;
    logic [DW:0]   v;
    logic [DW:0]   red;
    logic          ge;

    // The doubled digit plus carry stays below twice the radix, so one subtract is enough.
    assign v   = tok_in.first ? {{DW{1'b0}}, tok_in.carry} : {d_reg, tok_in.carry};
    assign ge  = (v >= radix);
    assign red = ge ? (v - radix) : v;

    always_comb
    begin
        d_next   = d_reg;
        cap_next = cap_reg;
        tok_next = tok_reg;
        if (adv)
        begin
            tok_next.valid = tok_in.valid;
            tok_next.first = tok_in.first;
            tok_next.last  = tok_in.last;
            tok_next.carry = ge;
            tok_next.neg   = tok_in.neg;
            if (tok_in.valid)
            begin
                d_next = red[DW-1:0];
                if (tok_in.last)
                begin
                    cap_next = red[DW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        cap_reg <= cap_next;
    end

    assign tok_out = tok_reg;
    assign cap     = cap_reg;

endmodule

>>> hdl/srt_emit.sv
// Output stage: checks the alphabet, drops leading zeros and sends one character per word.
module srt_emit #(
    parameter int MAX_BASE = srt_pkg::MAX_BASE_DEF,
    parameter int DW       = 4
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [srt_pkg::CFG_DATA_W-1:0]            alpha_low,
    input  logic [srt_pkg::CFG_DATA_W-1:0]            alpha_high,
    input  logic [srt_pkg::RLEN_W-1:0]                radix_length,
    input  logic                                      done,
    input  logic                                      done_neg,
    input  logic [srt_pkg::NUM_CELLS-1:0][DW-1:0]     caps,
    output logic                                      emit_free,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [srt_pkg::CHAR_W-1:0]                m_axis_tdata,
    output logic                                      m_axis_tlast
);
    import srt_pkg::*;

    localparam int IDX_W = $clog2(NUM_CELLS);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_CELLS - 1);

    logic [ALPHA_CHARS-1:0][CHAR_W-1:0] chars;
    logic                               ok_reg, ok_next;
    logic                               busy_reg, busy_next;
    logic                               sign_reg, sign_next;
    logic                               started_reg, started_next;
    logic [IDX_W-1:0]                   idx_reg, idx_next;
    logic [NUM_CELLS-1:0][DW-1:0]       buf_reg, buf_next;
    logic                               ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0]                  ochar_reg, ochar_next;
    logic                               olast_reg, olast_next;
    logic [DW-1:0]                      top;
    logic                               slot;
    logic                               skip;
    logic                               emit_sign;
    logic                               emit_dig;
    logic                               finish;
    logic                               load;

    assign chars = {alpha_high, alpha_low};

    // Registered alphabet check; user changes configuration only while idle, unenforced.
    always_comb
    begin
        ok_next = (radix_length >= RLEN_W'(MIN_RADIX)) && (radix_length <= RLEN_W'(MAX_BASE));
        for (int i = 0; i < MAX_BASE; i++)
        begin
            if (RLEN_W'(i) < radix_length)
            begin
                if (chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS)
                begin
                    ok_next = 1'b0;
                end
                for (int j = i + 1; j < MAX_BASE; j++)
                begin
                    if (RLEN_W'(j) < radix_length && chars[j] == chars[i])
                    begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    assign top       = buf_reg[NUM_CELLS-1];
    assign slot      = !ovalid_reg || m_axis_tready;
    assign skip      = busy_reg && !sign_reg && !started_reg && top == '0 && idx_reg != '0;
    assign emit_sign = busy_reg && sign_reg && slot;
    assign emit_dig  = busy_reg && !sign_reg && !skip && slot;
    assign finish    = emit_dig && idx_reg == '0;
    assign emit_free = !busy_reg || finish;
    assign load      = done && emit_free && ok_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        sign_next    = sign_reg;
        started_next = started_reg;
        idx_next     = idx_reg;
        buf_next     = buf_reg;
        if (load)
        begin
            busy_next    = 1'b1;
            sign_next    = done_neg;
            started_next = 1'b0;
            idx_next     = TOP_IDX;
            buf_next     = caps;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            if (emit_sign)
            begin
                sign_next = 1'b0;
            end
            if (skip || emit_dig)
            begin
                buf_next     = {buf_reg[NUM_CELLS-2:0], {DW{1'b0}}};
                idx_next     = idx_reg - IDX_W'(1);
                started_next = started_reg || emit_dig;
            end
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        if (emit_sign)
        begin
            ovalid_next = 1'b1;
            ochar_next  = CHAR_MINUS;
            olast_next  = 1'b0;
        end
        else if (emit_dig)
        begin
            ovalid_next = 1'b1;
            ochar_next  = chars[ALPHA_IDX_W'(top)];
            olast_next  = finish;
        end
        else if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg     <= 1'b0;
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ok_reg     <= ok_next;
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg    <= sign_next;
        started_reg <= started_next;
        idx_reg     <= idx_next;
        buf_reg     <= buf_next;
        ochar_reg   <= ochar_next;
        olast_reg   <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = ochar_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

>>> hdl/signed_int_to_radix_text_core.sv
// Top level of the signed integer to radix text converter.
//
// Input stream (s_axis): one word per value, tdata = value (signed 32 bits).
// Output stream (m_axis): one word per character, tdata = out_char, tlast = is_last.
// A negative value starts with '-', then the digits follow, most significant first.
// Configuration: cfg_index 0 and 1 load the two 64-bit halves of the digit alphabet,
// index 2 loads the radix length; cfg_ready is always high. An invalid alphabet
// (length below 2 or above MAX_BASE, a sign character, or a repeated character)
// swallows values and sends nothing.
// The magnitude enters a row of 32 digit cells one bit per cycle, MSB first, while
// the row advances; each cell doubles its digit, adds the carry from its lower
// neighbor and passes the new carry up one cell per cycle. The feed takes a new
// value only when idle or while it shifts in the last bit of the one before; the
// output stage drops leading zeros one per cycle, sends the sign first and takes
// the next finished value as it sends the last digit of the one before. The first
// digit appears once the value has left the row and its leading zeros are gone.
// A stalled receiver holds the output register; once the next finished value
// cannot enter the output stage, the whole cell row and the input stall.
// Reset empties the row and the output stage and clears the configuration.
module signed_int_to_radix_text_core #(
    parameter int MAX_BASE = srt_pkg::MAX_BASE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [srt_pkg::DATA_W-1:0]      s_axis_tdata,   // [31:0] value
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [srt_pkg::CHAR_W-1:0]      m_axis_tdata,   // [7:0] out_char
    output logic                            m_axis_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import srt_pkg::*;

    localparam int DW = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

    logic [CFG_DATA_W-1:0]        alpha_low_reg, alpha_low_next;
    logic [CFG_DATA_W-1:0]        alpha_high_reg, alpha_high_next;
    logic [RLEN_W-1:0]            radix_reg, radix_next;
    tok_t                         tok [NUM_CELLS+1];
    logic [NUM_CELLS-1:0][DW-1:0] caps;
    logic                         adv;
    logic                         done;
    logic                         emit_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        radix_next      = radix_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ALPHA_LOW:  alpha_low_next  = cfg_data;
                CFG_ALPHA_HIGH: alpha_high_next = cfg_data;
                CFG_RADIX_LEN:  radix_next      = cfg_data[RLEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            radix_reg      <= '0;
        end
        else
        begin
            alpha_low_reg  <= alpha_low_next;
            alpha_high_reg <= alpha_high_next;
            radix_reg      <= radix_next;
        end
    end

    assign done = tok[NUM_CELLS].valid && tok[NUM_CELLS].last;
    assign adv  = !done || emit_free;

    srt_feed u_feed (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .tok           (tok[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        srt_cell #(
            .DW (DW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .radix   (radix_reg[DW:0]),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1]),
            .cap     (caps[k])
        );
    end

    srt_emit #(
        .MAX_BASE (MAX_BASE),
        .DW       (DW)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .alpha_low     (alpha_low_reg),
        .alpha_high    (alpha_high_reg),
        .radix_length  (radix_reg),
        .done          (done),
        .done_neg      (tok[NUM_CELLS].neg),
        .caps          (caps),
        .emit_free     (emit_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> hdl/srt_checker.sv
// Port-level checks for the radix text converter, bound to its top level.
module srt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [srt_pkg::CHAR_W-1:0]  m_axis_tdata,
    input  logic                        m_axis_tlast
);
    import srt_pkg::*;

    // A stalled word holds its character and end mark.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // The sign is always followed by at least one digit.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata == CHAR_MINUS |-> !m_axis_tlast)
        else $error("minus sign marked as last character");

    // A valid alphabet never holds a plus sign, so none can be sent.
    a_no_plus: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata != CHAR_PLUS)
        else $error("plus sign sent");

    // Two minus signs never follow each other.
    a_single_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata == CHAR_MINUS |=>
            !(m_axis_tvalid && m_axis_tdata == CHAR_MINUS))
        else $error("minus sign repeated");

endmodule

bind signed_int_to_radix_text_core srt_checker u_srt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> tb/sv/signed_int_to_radix_text_core_tb.sv
// Self-checking testbench for the signed integer to radix text converter.
`timescale 1ns / 1ps

module signed_int_to_radix_text_core_tb;
    import srt_pkg::*;

    localparam int MAX_BASE      = MAX_BASE_DEF;
    localparam int SETTLE_CYCLES = 256;
    localparam int RANDOM_VALUES = 290;
    localparam longint TIMEOUT_NS = 4_000_000;

    // Index 3 is beyond the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    typedef enum {
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_SIGN,
        FLAW_REPEAT
    } alpha_flaw_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the configuration registers.
    logic [CFG_DATA_W-1:0] alpha_lo = '0;
    logic [CFG_DATA_W-1:0] alpha_hi = '0;
    logic [RLEN_W-1:0]     radix_len = '0;

    logic [DATA_W-1:0] pending_values[$];
    text_char_t        expected_text[$];
    int                mismatch_count = 0;
    int                sender_idle_pct = 0;
    int                receiver_idle_pct = 0;

    signed_int_to_radix_text_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [CHAR_W-1:0] alpha_char(input int idx);
        logic [CFG_DATA_W-1:0] w;
        w = (idx < 8) ? alpha_lo : alpha_hi;
        return w[(idx % 8) * CHAR_W +: CHAR_W];
    endfunction

    function automatic bit alphabet_valid();
        int n;
        logic [CHAR_W-1:0] c;
        n = int'(radix_len);
        if (n < MIN_RADIX || n > MAX_BASE)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            c = alpha_char(i);
            if (c == CHAR_PLUS || c == CHAR_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (alpha_char(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queues the characters that one value turns into under the current alphabet.
    task automatic predict_text(input logic [DATA_W-1:0] raw);
        logic              neg;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] radix;
        logic [3:0]        digits[DATA_W];
        int                nd;
        if (!alphabet_valid())
            return;
        neg = raw[DATA_W-1];
        mag = neg ? (~raw + 1'b1) : raw;
        radix = DATA_W'(radix_len);
        nd = 0;
        do
        begin
            digits[nd] = 4'(mag % radix);
            nd++;
            mag = mag / radix;
        end
        while (mag != 0 && nd < DATA_W);
        if (neg)
            expected_text.push_back('{ch: CHAR_MINUS, last: 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            expected_text.push_back('{ch: alpha_char(int'(digits[k])), last: (k == 0)});
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_ALPHA_LOW:  alpha_lo = data;
            CFG_ALPHA_HIGH: alpha_hi = data;
            CFG_RADIX_LEN:  radix_len = data[RLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_alphabet(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                                 input logic [CFG_DATA_W-1:0] len_word);
        write_reg(CFG_ALPHA_LOW, lo);
        write_reg(CFG_ALPHA_HIGH, hi);
        write_reg(CFG_RADIX_LEN, len_word);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_random_alphabet(input bit well_formed);
        logic [CHAR_W-1:0]     chars[ALPHA_CHARS];
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [CFG_DATA_W-1:0] len_word;
        alpha_flaw_t           flaw;
        int                    n;
        int                    i;
        int                    j;
        bit                    clash;
        if ($urandom_range(3) == 0)
            n = $urandom_range(1) ? MIN_RADIX : ALPHA_CHARS;
        else
            n = $urandom_range(ALPHA_CHARS, MIN_RADIX);
        for (i = 0; i < ALPHA_CHARS; i++)
            chars[i] = 8'($urandom_range(255));
        for (i = 0; i < n; i++)
        begin
            do
            begin
                chars[i] = ($urandom_range(15) == 0) ? 8'h00 : 8'($urandom_range(255));
                clash = (chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS);
                for (j = 0; j < i; j++)
                    if (chars[j] == chars[i])
                        clash = 1'b1;
            end
            while (clash);
        end
        if (!well_formed)
        begin
            flaw = alpha_flaw_t'($urandom_range(3));
            case (flaw)
                FLAW_SHORT: n = $urandom_range(1);
                FLAW_LONG:  n = $urandom_range(31, ALPHA_CHARS + 1);
                FLAW_SIGN:  chars[$urandom_range(n - 1)] = $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
                default:
                begin
                    i = $urandom_range(n - 1);
                    j = $urandom_range(n - 2);
                    if (j >= i)
                        j++;
                    chars[j] = chars[i];
                end
            endcase
        end
        for (i = 0; i < 8; i++)
        begin
            lo[i * CHAR_W +: CHAR_W] = chars[i];
            hi[i * CHAR_W +: CHAR_W] = chars[i + 8];
        end
        // Only the low bits of the length word count; the rest is noise.
        len_word = {$urandom, $urandom};
        len_word[RLEN_W-1:0] = RLEN_W'(n);
        load_alphabet(lo, hi, len_word);
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(5))
            0: return DATA_W'($urandom_range(40));
            1: return -DATA_W'($urandom_range(40, 1));
            2:
            begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_results();
        while (pending_values.size() != 0 || s_axis_tvalid || expected_text.size() != 0)
            @(posedge clk);
    endtask

    // Values swallowed by an invalid alphabet leave no trace, so allow the row to empty.
    task automatic wait_quiet();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: presents queued values and records the text each accepted word must produce.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_text(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_values.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted character word against the oldest expected one.
    always @(posedge clk)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch($sformatf("character %02h with no text pending", m_axis_tdata));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_axis_tdata !== want.ch)
                        report_mismatch($sformatf("character %02h, wanted %02h",
                                                  m_axis_tdata, want.ch));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("tlast %b, wanted %b on character %02h",
                                                  m_axis_tlast, want.last, want.ch));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        int  sent;
        int  chunk;
        int  count;
        bit  well_formed;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_idle_pct   = 6;
        receiver_idle_pct = 69;

        // Registers still at reset: the empty alphabet converts nothing.
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'hFFFF_FFFF);
        wait_quiet();

        // Decimal; bytes past the length hold signs and repeats that must be ignored.
        load_alphabet(64'h3736_3534_3332_3130, 64'h2B2D_3130_2B2D_3938, 64'd10);
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'h0000_0001);
        pending_values.push_back(32'hFFFF_FFFF);
        pending_values.push_back(32'h0000_0009);
        pending_values.push_back(32'hFFFF_FFF6);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        wait_quiet();

        // Smallest radix gives the longest text, 33 characters for the most negative value.
        load_alphabet(64'h2D2D_3131_3131_3130, 64'h2B2B_2B2B_2B2B_2B2B, 64'd2);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h0000_0005);
        wait_quiet();

        // Full radix with a zero byte as digit zero and an all-ones byte as the top digit.
        load_alphabet(64'h4746_4544_4342_4100, 64'hFF4E_4D4C_4B4A_4948, 64'd16);
        pending_values.push_back(32'h0000_0000);
        pending_values.push_back(32'h0000_00FF);
        pending_values.push_back(32'hDEAD_BEEF);
        wait_quiet();

        // A write to an index past the list leaves the alphabet alone.
        write_reg(CFG_UNUSED, 64'h0000_0000_0000_0003);
        cfg_valid <= 1'b0;
        pending_values.push_back(32'hFFFF_FF00);
        wait_quiet();

        // Invalid alphabets: too short, too long, a plus, a minus, a repeated character.
        load_alphabet(64'h3736_3534_3332_3130, 64'h2B2D_3130_2B2D_3938, 64'd1);
        pending_values.push_back(32'h0000_0007);
        wait_quiet();
        load_alphabet(64'h4746_4544_4342_4100, 64'hFF4E_4D4C_4B4A_4948, 64'hFFFF_FFFF_FFFF_FFF1);
        pending_values.push_back(32'h8000_0000);
        wait_quiet();
        load_alphabet(64'h3736_3534_2B32_3130, 64'h2B2D_3130_2B2D_3938, 64'd10);
        pending_values.push_back(32'h0000_0123);
        wait_quiet();
        load_alphabet(64'h3736_3534_3332_3130, 64'h2B2D_3130_2B2D_2D38, 64'd10);
        pending_values.push_back(32'hFFFF_FEDC);
        wait_quiet();
        load_alphabet(64'h4746_4544_4342_4100, 64'h004E_4D4C_4B4A_4948, 64'd16);
        pending_values.push_back(32'h0000_0011);
        wait_quiet();

        sent  = 0;
        chunk = 0;
        while (sent < RANDOM_VALUES)
        begin
            if (sent < RANDOM_VALUES / 3)
            begin
                sender_idle_pct   = 6;
                receiver_idle_pct = 69;
            end
            else if (sent < 2 * RANDOM_VALUES / 3)
            begin
                sender_idle_pct   = 69;
                receiver_idle_pct = 6;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            well_formed = ($urandom_range(5) != 0);
            load_random_alphabet(well_formed);
            count = well_formed ? $urandom_range(40, 15) : 4;
            for (int i = 0; i < count; i++)
            begin
                pending_values.push_back(random_value());
                // Now and then hold the rest back until every character has come out.
                if (chunk % 3 == 0 && i == count / 2)
                    wait_results();
            end
            if (well_formed)
                sent += count;
            chunk++;
            wait_quiet();
        end

        if (mismatch_count == 0)
            $display("signed_int_to_radix_text_core_tb: clean");
        else
            $display("signed_int_to_radix_text_core_tb: errors");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("signed_int_to_radix_text_core_tb: errors");
        $finish;
    end

endmodule
